// File: rtl/core/rds_pkg.sv
// Types and constants shared by the radix digit splitter.
// No dependencies.
package rds_pkg;

  localparam logic [4:0] BlankCode = 5'd17;
  localparam logic [7:0] BaseMin   = 8'd2;
  localparam logic [7:0] BaseMax   = 8'd16;
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned StagesPerDigit = 4;

  // State of one word as it moves down the divider pipeline
  typedef struct packed {
    logic [31:0] num;   // dividend bits, quotient shifted in from the bottom
    logic [3:0]  rem;   // partial remainder
    logic [4:0]  base;
    logic        err;
    logic        done;  // quotient has reached zero
    logic [5:0]  cnt;   // real digits so far
    logic [5:0]  len;   // positions to fill
  } rds_ctl_t;

endpackage

// File: rtl/core/rds_in_if.sv
// Input channel of the radix digit splitter: number and base.
// No dependencies.
interface rds_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] number;
  logic [7:0]  base;
  modport source (output valid, number, base, input ready);
  modport sink   (input valid, number, base, output ready);
endinterface

// File: rtl/core/rds_out_if.sv
// Output channel of the radix digit splitter: one display position per word.
// No dependencies.
interface rds_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] digit;
  logic [4:0] position;
  logic       last;
  logic [5:0] used_count;
  logic       base_error;
  modport source (output valid, digit, position, last, used_count, base_error, input ready);
  modport sink   (input valid, digit, position, last, used_count, base_error, output ready);
endinterface

// File: rtl/core/rds_stage.sv
// One divider pipeline stage: eight restoring division steps on the quotient.
// Depends on rds_pkg.
module rds_stage import rds_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 8,
  parameter int unsigned STAGE      = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  rds_ctl_t                  ctl_i,
  input  logic [MAX_DIGITS*4-1:0]   dig_i,
  output logic                      valid_o,
  output rds_ctl_t                  ctl_o,
  output logic [MAX_DIGITS*4-1:0]   dig_o
);

  localparam int unsigned DigitIdx = STAGE / StagesPerDigit;
  localparam bit          LastPart = (STAGE % StagesPerDigit) == (StagesPerDigit - 1);

  logic                    valid_q;
  rds_ctl_t                ctl_q, ctl_d;
  logic [MAX_DIGITS*4-1:0] dig_q, dig_d;

  always_comb begin
    logic [31:0] n;
    logic [3:0]  r;
    logic [4:0]  t;
    n = ctl_i.num;
    r = ctl_i.rem;
    for (int i = 0; i < StepsPerStage; i++) begin
      t = {r, n[31]};
      n = {n[30:0], 1'b0};
      if (t >= ctl_i.base) begin
        t    = t - ctl_i.base;
        n[0] = 1'b1;
      end
      r = t[3:0];
    end
    ctl_d     = ctl_i;
    ctl_d.num = n;
    dig_d     = dig_i;
    if (LastPart) begin
      // digit complete: store remainder, restart for the next digit
      dig_d[DigitIdx*4 +: 4] = r;
      ctl_d.rem = 4'd0;
      if (!ctl_i.done) begin
        ctl_d.cnt  = 6'(DigitIdx + 1);
        ctl_d.done = (n == 32'd0);
      end
    end else begin
      ctl_d.rem = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= ctl_d;
      dig_q <= dig_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign dig_o   = dig_q;

endmodule

// File: rtl/core/radix_digit_splitter.sv
// Radix digit splitter: 32-bit number to base 2..16 digits, one position a word.
// Path: 4*MAX_DIGITS divider stages, then the serialiser load registers, then the output
// register. New numbers are taken while the serialiser is busy, until a finished word waits
// at the pipeline end. The serialiser loads a word, then gives one position a cycle while the output is not stalled.
// Reset clears all valid flags and sets digit_count to 8; no clearing pass.
module radix_digit_splitter import rds_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  rds_in_if.sink    in_i,
  rds_out_if.source out_o
);

  localparam int unsigned NumStages = MAX_DIGITS * StagesPerDigit;
  localparam int unsigned DigW      = MAX_DIGITS * 4;
  localparam int unsigned IdxW      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [5:0]  MaxLen    = 6'(MAX_DIGITS);

  logic [5:0] cfg_q;
  logic [5:0] eff_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 6'd8;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    eff_len = cfg_q;
    if (eff_len == 6'd0) eff_len = 6'd1;
    if (eff_len > MaxLen) eff_len = MaxLen;
  end

  // divider pipeline
  logic            vld [NumStages+1];
  rds_ctl_t        ctl [NumStages+1];
  logic [DigW-1:0] dig [NumStages+1];
  logic            pipe_en;

  always_comb begin
    vld[0]      = in_i.valid;
    ctl[0].num  = in_i.number;
    ctl[0].rem  = 4'd0;
    ctl[0].base = in_i.base[4:0];
    ctl[0].err  = (in_i.base < BaseMin) || (in_i.base > BaseMax);
    ctl[0].done = 1'b0;
    ctl[0].cnt  = 6'd0;
    ctl[0].len  = eff_len;
    dig[0]      = '0;
  end

  assign in_i.ready = pipe_en;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    rds_stage #(.MAX_DIGITS(MAX_DIGITS), .STAGE(s)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (vld[s]),
      .ctl_i   (ctl[s]),
      .dig_i   (dig[s]),
      .valid_o (vld[s+1]),
      .ctl_o   (ctl[s+1]),
      .dig_o   (dig[s+1])
    );
  end

  // output serialiser
  logic       busy_q;
  logic [4:0] pos_q;
  logic [3:0] dig_q [MAX_DIGITS];
  logic [5:0] cnt_q, len_q;
  logic       err_q;
  logic       ser_load, emit, emit_last;

  logic       out_valid_q;
  logic [4:0] out_digit_q, out_pos_q;
  logic       out_last_q, out_err_q;
  logic [5:0] out_used_q;

  assign ser_load  = vld[NumStages] && !busy_q;
  assign pipe_en   = !vld[NumStages] || ser_load;
  assign emit      = busy_q && (!out_valid_q || out_o.ready);
  assign emit_last = err_q || ({1'b0, pos_q} == len_q - 6'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (ser_load) begin
        busy_q <= 1'b1;
        pos_q  <= 5'd0;
      end else if (emit) begin
        if (emit_last) busy_q <= 1'b0;
        else           pos_q  <= pos_q + 5'd1;
      end
      if (emit)              out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      for (int k = 0; k < MAX_DIGITS; k++) dig_q[k] <= dig[NumStages][k*4 +: 4];
      cnt_q <= (ctl[NumStages].cnt < ctl[NumStages].len) ?
               ctl[NumStages].cnt : ctl[NumStages].len;
      len_q <= ctl[NumStages].len;
      err_q <= ctl[NumStages].err;
    end
    if (emit) begin
      if (err_q || ({1'b0, pos_q} >= cnt_q)) out_digit_q <= BlankCode;
      else                                   out_digit_q <= {1'b0, dig_q[pos_q[IdxW-1:0]]};
      out_pos_q  <= pos_q;
      out_last_q <= emit_last;
      out_used_q <= (emit_last && !err_q) ? cnt_q : 6'd0;
      out_err_q  <= err_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.digit      = out_digit_q;
  assign out_o.position   = out_pos_q;
  assign out_o.last       = out_last_q;
  assign out_o.used_count = out_used_q;
  assign out_o.base_error = out_err_q;

endmodule

// File: rtl/core/rds_checker.sv
// Port-level checks for the radix digit splitter, bound to the top level.
// Depends on rds_pkg and radix_digit_splitter.
module rds_checker import rds_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] digit_i,
  input logic [4:0] position_i,
  input logic       last_i,
  input logic [5:0] used_count_i,
  input logic       base_error_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(digit_i) && $stable(position_i) && $stable(last_i))
    else $error("output word changed while stalled");

  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && base_error_i |-> last_i && position_i == 5'd0 && used_count_i == 6'd0
      && digit_i == BlankCode)
    else $error("bad base word malformed");

  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> used_count_i == 6'd0)
    else $error("count given before end of run");

  a_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> digit_i <= 5'd15 || digit_i == BlankCode)
    else $error("digit code out of range");

endmodule

bind radix_digit_splitter rds_checker u_rds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .digit_i      (out_o.digit),
  .position_i   (out_o.position),
  .last_i       (out_o.last),
  .used_count_i (out_o.used_count),
  .base_error_i (out_o.base_error)
);
